[hw/rtl/gbt_pkg.sv]
// ----------------------------------------------------------------------------
// gbt_pkg: shared types and constants
// Pixel and window types, field widths, register indexes and kernel weights
// for the 5x5 blur and threshold unit.
// ----------------------------------------------------------------------------
package gbt_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned RowW    = 12;
  localparam int unsigned OutColW = 10;
  localparam int unsigned WidthW  = 11;
  localparam int unsigned CfgW    = 12;
  localparam int unsigned ThrW    = 8;
  localparam int unsigned SumW    = 18;

  localparam int unsigned MinSize   = 7;
  localparam int unsigned MaxHeight = 4095;

  localparam logic [WidthW-1:0] WidthRst  = 11'd640;
  localparam logic [RowW-1:0]   HeightRst = 12'd480;
  localparam logic [ThrW-1:0]   ThrRst    = 8'd120;

  localparam logic [PixW-1:0] PixBlack = 8'd0;
  localparam logic [PixW-1:0] PixWhite = 8'd255;

  // kernel weights in thousandths, grouped by symmetric position
  localparam logic [7:0] WCorner = 8'd3;
  localparam logic [7:0] WEdge   = 8'd13;
  localparam logic [7:0] WMidOut = 8'd22;
  localparam logic [7:0] WDiag   = 8'd60;
  localparam logic [7:0] WCross  = 8'd98;
  localparam logic [7:0] WCenter = 8'd162;
  localparam logic [9:0] ThrScale = 10'd1000;

  typedef enum logic [1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1,
    CfgThreshold   = 2'd2,
    CfgUnused      = 2'd3
  } cfg_idx_e;

  typedef logic [PixW-1:0] pix_t;
  typedef pix_t [4:0][4:0] window_t;

  typedef struct packed {
    logic [RowW-1:0]    row;
    logic [OutColW-1:0] col;
    logic               inner;
    logic               eof;
  } res_meta_t;

endpackage

[hw/rtl/gbt_if.sv]
// ----------------------------------------------------------------------------
// gbt_if: stream channels
// Valid/ready channels for input pixels and binary results.
// ----------------------------------------------------------------------------
interface gbt_pix_if;
  logic                    valid;
  logic                    ready;
  logic [gbt_pkg::PixW-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface gbt_res_if;
  logic                        valid;
  logic                        ready;
  logic [gbt_pkg::RowW-1:0]    out_row;
  logic [gbt_pkg::OutColW-1:0] out_col;
  logic [gbt_pkg::PixW-1:0]    out_value;
  logic                        end_of_frame;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output end_of_frame, input ready);
  modport sink   (input valid, input out_row, input out_col, input out_value,
                  input end_of_frame, output ready);
endinterface

[hw/rtl/gbt_ram.sv]
// ----------------------------------------------------------------------------
// gbt_ram: generic simple dual-port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gbt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/gbt_kernel.sv]
// ----------------------------------------------------------------------------
// gbt_kernel: weighted 5x5 sum and threshold compare
// Adds window pixels of equal weight into registered group sums, then
// weights the groups and compares against threshold times 1000.
// ----------------------------------------------------------------------------
module gbt_kernel (
  input  logic             clk_i,
  input  logic             load_i,
  input  gbt_pkg::window_t win_i,
  input  logic [gbt_pkg::ThrW-1:0] thr_i,
  output logic             white_o
);
  import gbt_pkg::*;

  logic [9:0]  g_corner_d, g_corner_q;
  logic [10:0] g_edge_d,   g_edge_q;
  logic [9:0]  g_midout_d, g_midout_q;
  logic [9:0]  g_diag_d,   g_diag_q;
  logic [9:0]  g_cross_d,  g_cross_q;
  logic [7:0]  g_center_d, g_center_q;
  logic [SumW-1:0] sum;
  logic [SumW-1:0] limit;

  // pixels sharing a weight
  always_comb begin
    g_corner_d = 10'(win_i[0][0]) + 10'(win_i[0][4]) + 10'(win_i[4][0]) + 10'(win_i[4][4]);
    g_edge_d   = 11'(win_i[0][1]) + 11'(win_i[0][3]) + 11'(win_i[1][0]) + 11'(win_i[1][4])
               + 11'(win_i[3][0]) + 11'(win_i[3][4]) + 11'(win_i[4][1]) + 11'(win_i[4][3]);
    g_midout_d = 10'(win_i[0][2]) + 10'(win_i[2][0]) + 10'(win_i[2][4]) + 10'(win_i[4][2]);
    g_diag_d   = 10'(win_i[1][1]) + 10'(win_i[1][3]) + 10'(win_i[3][1]) + 10'(win_i[3][3]);
    g_cross_d  = 10'(win_i[1][2]) + 10'(win_i[2][1]) + 10'(win_i[2][3]) + 10'(win_i[3][2]);
    g_center_d = win_i[2][2];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      g_corner_q <= g_corner_d;
      g_edge_q   <= g_edge_d;
      g_midout_q <= g_midout_d;
      g_diag_q   <= g_diag_d;
      g_cross_q  <= g_cross_d;
      g_center_q <= g_center_d;
    end
  end

  // constant weights, exact integer sum
  always_comb begin
    sum = SumW'(g_corner_q) * SumW'(WCorner)
        + SumW'(g_edge_q)   * SumW'(WEdge)
        + SumW'(g_midout_q) * SumW'(WMidOut)
        + SumW'(g_diag_q)   * SumW'(WDiag)
        + SumW'(g_cross_q)  * SumW'(WCross)
        + SumW'(g_center_q) * SumW'(WCenter);
    limit = SumW'(thr_i) * SumW'(ThrScale);
  end

  assign white_o = (sum >= limit);

endmodule

[hw/rtl/gaussian_blur_threshold_5x5_unit.sv]
// ----------------------------------------------------------------------------
// gaussian_blur_threshold_5x5_unit: streaming 5x5 blur with binary threshold
// Line stores and a 5x5 window feed a weighted sum that is thresholded to
// black or white for every interior centre pixel.
// ----------------------------------------------------------------------------
// usage
//   pix_i takes 8-bit grey pixels in raster order, one word per cycle while pix_i.ready is high.
//   once four rows and four columns of a row have arrived, each pixel gives
//   one result word on res_o for the centre two rows up and two columns left;
//   centres in the three-pixel border come out 0, others 0 or 255
//   end_of_frame marks the result made by the last pixel of a frame
//   cfg_we_i / cfg_idx_i / cfg_data_i write image width, height and threshold
//   while the stream is idle
// timing
//   one pixel per cycle sustained while res_o is ready; a result passes the line
//   store read, window shift, group sums and output compare registers in order
//   the line store is one ram with four rows packed per word, read when its
//   pixel is taken, ahead of the window update, and written back at the same column
// stall and reset
//   a stall on res_o backs up the pipeline and drops pix_i.ready the same
//   cycle once every stage is full; nothing is lost or repeated
//   reset clears the counters, window and valid flags and restores the
//   register defaults 640 x 480, threshold 120; the line store needs no clear
// ----------------------------------------------------------------------------
module gaussian_blur_threshold_5x5_unit #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  gbt_pix_if.sink                 pix_i,
  gbt_res_if.source               res_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [gbt_pkg::CfgW-1:0] cfg_data_i
);
  import gbt_pkg::*;

  localparam int unsigned ColAw = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned LineW = 4 * PixW;

  // configuration registers
  logic [WidthW-1:0] width_q;
  logic [RowW-1:0]   height_q;
  logic [ThrW-1:0]   thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      thr_q    <= ThrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgImageWidth:  width_q  <= cfg_data_i[WidthW-1:0];
        CfgImageHeight: height_q <= cfg_data_i[RowW-1:0];
        CfgThreshold:   thr_q    <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size, clamped to the usable range
  logic [12:0]     w_sat;
  logic [RowW-1:0] h_sat;

  always_comb begin
    if (13'(width_q) < 13'(MinSize)) begin
      w_sat = 13'(MinSize);
    end else if (13'(width_q) > 13'(MAX_WIDTH)) begin
      w_sat = 13'(MAX_WIDTH);
    end else begin
      w_sat = 13'(width_q);
    end
    h_sat = (height_q < RowW'(MinSize)) ? RowW'(MinSize) : height_q;
  end

  // pipeline handshake, every stage moves when the one after it frees up
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic out_free, s3_free, s2_free, s1_free;
  logic s1_adv, s2_adv;
  logic accept;

  assign out_free = !out_valid_q || res_o.ready;
  assign s3_free  = !s3_valid_q || out_free;
  assign s2_free  = !s2_valid_q || s3_free;
  assign s1_free  = !s1_valid_q || s2_free;
  assign s1_adv   = s1_valid_q && s2_free;
  assign s2_adv   = s2_valid_q && s3_free;
  assign accept   = pix_i.valid && s1_free;
  assign pix_i.ready = s1_free;

  // raster position of the next pixel
  logic [ColAw-1:0] col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [12:0]      col_ext, col_m2;
  logic             last_col, last_row, emit;
  res_meta_t        meta_d;

  always_comb begin
    col_ext  = 13'(col_q);
    col_m2   = col_ext - 13'd2;
    last_col = (col_ext >= w_sat - 13'd1);
    last_row = (row_q >= h_sat - RowW'(1));
    emit     = (row_q >= RowW'(4)) && (col_ext >= 13'd4);
    meta_d.row   = row_q - RowW'(2);
    meta_d.col   = col_m2[OutColW-1:0];
    meta_d.inner = (row_q >= RowW'(5)) && (col_ext >= 13'd5)
                && (13'(row_q) + 13'd1 < 13'(h_sat)) && (col_ext + 13'd1 < w_sat);
    meta_d.eof   = last_col && last_row;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + RowW'(1);
    end else begin
      col_d = col_q + ColAw'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: line store read in flight, pixel and position held
  pix_t             s1_pix_q;
  logic [ColAw-1:0] s1_col_q;
  logic             s1_emit_q;
  res_meta_t        s1_meta_q;
  logic [LineW-1:0] line_rd, line_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pix_i.pixel;
      s1_col_q  <= col_q;
      s1_emit_q <= emit;
      s1_meta_q <= meta_d;
    end
  end

  // four rows per word: oldest row in the low byte; each row moves up by one
  assign line_wr = {s1_pix_q, line_rd[LineW-1:PixW]};

  gbt_ram #(
    .WIDTH (LineW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (line_wr),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (line_rd)
  );

  // stage 2: window shifts left, new column enters on the right
  window_t   win_q;
  res_meta_t s2_meta_q;
  pix_t [4:0] new_col;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      new_col[i] = line_rd[i*PixW +: PixW];
    end
    new_col[4] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        for (int i = 0; i < 5; i++) begin
          for (int j = 0; j < 4; j++) begin
            win_q[i][j] <= win_q[i][j+1];
          end
          win_q[i][4] <= new_col[i];
        end
      end
      if (s2_free) begin
        s2_valid_q <= s1_adv && s1_emit_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_meta_q <= s1_meta_q;
    end
  end

  // stage 3: group sums registered inside the kernel, then weighted compare
  res_meta_t s3_meta_q;
  logic      white;

  gbt_kernel u_kernel (
    .clk_i   (clk_i),
    .load_i  (s2_adv),
    .win_i   (win_q),
    .thr_i   (thr_q),
    .white_o (white)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_free) begin
      s3_valid_q <= s2_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s3_meta_q <= s2_meta_q;
    end
  end

  // output register, holds while the receiver stalls
  logic       s3_adv;
  res_meta_t  out_meta_q;
  pix_t       out_value_q;

  assign s3_adv = s3_valid_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s3_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_adv) begin
      out_meta_q  <= s3_meta_q;
      out_value_q <= (s3_meta_q.inner && white) ? PixWhite : PixBlack;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.out_row      = out_meta_q.row;
  assign res_o.out_col      = out_meta_q.col;
  assign res_o.out_value    = out_value_q;
  assign res_o.end_of_frame = out_meta_q.eof;

endmodule

[tb/gaussian_blur_threshold_5x5_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_blur_threshold_5x5_checker: result predictor and scoreboard
// Watches the pixel and result channels and the register port, keeps its own
// line stores, window and counters, and compares every result word with the
// expected blurred and thresholded centre pixel.
// ----------------------------------------------------------------------------
module gaussian_blur_threshold_5x5_checker #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  gbt_pix_if                       pix_i,
  gbt_res_if                       res_i,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [gbt_pkg::CfgW-1:0] cfg_data_i,
  output int unsigned              errors_o,
  output int unsigned              pending_o,
  output int unsigned              checked_o,
  output int unsigned              white_o,
  output int unsigned              frames_o
);
  import gbt_pkg::*;

  typedef struct packed {
    logic [RowW-1:0]    row;
    logic [OutColW-1:0] col;
    pix_t               value;
    logic               eof;
  } blur_word_t;

  localparam int unsigned Kernel [5][5] = '{
    '{WCorner, WEdge,  WMidOut, WEdge,  WCorner},
    '{WEdge,   WDiag,  WCross,  WDiag,  WEdge  },
    '{WMidOut, WCross, WCenter, WCross, WMidOut},
    '{WEdge,   WDiag,  WCross,  WDiag,  WEdge  },
    '{WCorner, WEdge,  WMidOut, WEdge,  WCorner}
  };

  logic [WidthW-1:0] width_q;
  logic [RowW-1:0]   height_q;
  logic [ThrW-1:0]   thr_q;
  pix_t              line_mem [4][MAX_WIDTH];
  window_t           win_q;
  int unsigned       col_q;
  int unsigned       row_q;
  blur_word_t        expected_q [$];
  int unsigned       errors;
  int unsigned       checked;
  int unsigned       whites;
  int unsigned       frames;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned lo,
                                             int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // shift one pixel through line stores and window, queue the centre result
  task automatic predict_pixel(input pix_t px);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned idx;
    int unsigned cr;
    int unsigned cc;
    int unsigned sum;
    pix_t        column [5];
    logic        last_col;
    logic        last_row;
    blur_word_t  word;
    w = clamp_size(width_q, MinSize, MAX_WIDTH);
    h = clamp_size(height_q, MinSize, MaxHeight);
    c = col_q;
    r = row_q;
    idx = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
    last_col = (c >= w - 1);
    last_row = (r >= h - 1);
    for (int i = 0; i < 4; i++) column[i] = line_mem[i][idx];
    column[4] = px;
    for (int i = 0; i < 4; i++) line_mem[i][idx] = column[i+1];
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) win_q[i][j] = win_q[i][j+1];
      win_q[i][4] = column[i];
    end
    if (r >= 4 && c >= 4) begin
      cr = r - 2;
      cc = c - 2;
      word.row   = RowW'(cr);
      word.col   = OutColW'(cc);
      word.value = PixBlack;
      word.eof   = last_col && last_row;
      if (cr >= 3 && cc >= 3 && cr < h - 3 && cc < w - 3) begin
        sum = 0;
        for (int i = 0; i < 5; i++)
          for (int j = 0; j < 5; j++)
            sum += Kernel[i][j] * int'(win_q[i][j]);
        word.value = (sum < int'(thr_q) * int'(ThrScale)) ? PixBlack : PixWhite;
      end
      expected_q.push_back(word);
    end
    if (last_col) begin
      col_q = 0;
      row_q = last_row ? 0 : r + 1;
    end else begin
      col_q = c + 1;
    end
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_word();
    blur_word_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t unexpected result word: expected none, actual row %0d col %0d",
               $time, res_i.out_row, res_i.out_col);
    end else begin
      want = expected_q.pop_front();
      report_field("out_row", want.row, res_i.out_row);
      report_field("out_col", want.col, res_i.out_col);
      report_field("out_value", want.value, res_i.out_value);
      report_field("end_of_frame", want.eof, res_i.end_of_frame);
      checked++;
      if (want.value == PixWhite) whites++;
      if (want.eof) frames++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  = WidthRst;
      height_q = HeightRst;
      thr_q    = ThrRst;
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < MAX_WIDTH; j++) line_mem[i][j] = PixBlack;
      win_q   = '0;
      col_q   = 0;
      row_q   = 0;
      expected_q.delete();
      errors  = 0;
      checked = 0;
      whites  = 0;
      frames  = 0;
      errors_o  <= 0;
      pending_o <= 0;
      checked_o <= 0;
      white_o   <= 0;
      frames_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgImageWidth:  width_q  = cfg_data_i[WidthW-1:0];
          CfgImageHeight: height_q = cfg_data_i[RowW-1:0];
          CfgThreshold:   thr_q    = cfg_data_i[ThrW-1:0];
          default: ;
        endcase
      end
      // compare before predicting: a word can never belong to a pixel of this edge
      if (res_i.valid && res_i.ready) check_word();
      if (pix_i.valid && pix_i.ready) predict_pixel(pix_i.pixel);
      errors_o  <= errors;
      pending_o <= expected_q.size();
      checked_o <= checked;
      white_o   <= whites;
      frames_o  <= frames;
    end
  end

endmodule

[tb/gaussian_blur_threshold_5x5_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_blur_threshold_5x5_unit_test: stream test of the blur unit
// Drives pixel frames of many sizes and thresholds through the unit with
// random idle bursts on both channels; a checker beside the unit predicts
// each result word and this top gives the verdict.
// ----------------------------------------------------------------------------
module gaussian_blur_threshold_5x5_unit_test;
  import gbt_pkg::*;

  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned StallLimit  = 1000;  // cycles with no word moving
  localparam int unsigned DrainCycles = 8;     // extra wait once no word is expected
  localparam int unsigned RandomItems = 200;
  localparam int unsigned CalmItems   = 80;    // tail of the run without idling
  localparam pix_t        EdgeLevel   = 8'd100;

  typedef enum int unsigned {
    FillNoise,
    FillNearLevel,
    FillBlobs,
    FillFlat
  } fill_e;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  cfg_idx_e        cfg_idx;
  logic [CfgW-1:0] cfg_data;
  logic            idle_en;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned whites;
  int unsigned frames;
  int unsigned pixels_sent;
  int unsigned quiet_cycles;

  gbt_pix_if pix_if ();
  gbt_res_if res_if ();

  gaussian_blur_threshold_5x5_unit #(
    .MAX_WIDTH (MaxWidth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  gaussian_blur_threshold_5x5_checker #(
    .MAX_WIDTH (MaxWidth)
  ) checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if),
    .res_i      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked),
    .white_o    (whites),
    .frames_o   (frames)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // result side back-pressure: random stall bursts
  initial begin
    res_if.ready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end
    end
  end

  // watchdog: a long stretch with no word moving on either channel is a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("timeout after %0d idle cycles, %0d words still expected",
                 quiet_cycles, pending);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // wait until every expected word has come, then let the pipeline empty;
  // the first edge makes sure the checker has seen the last accepted pixel
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // register writes happen only with the stream stopped and drained
  task automatic write_regs(input logic [2:0] mask, input int unsigned w_raw,
                            input int unsigned h_raw, input int unsigned thr);
    cfg_idx_e idx;
    pix_if.valid <= 1'b0;
    wait_drained();
    for (int i = 0; i < 3; i++) begin
      if (mask[i]) begin
        idx = cfg_idx_e'(i);
        cfg_we  <= 1'b1;
        cfg_idx <= idx;
        case (idx)
          CfgImageWidth:  cfg_data <= CfgW'(w_raw);
          CfgImageHeight: cfg_data <= CfgW'(h_raw);
          default:        cfg_data <= CfgW'(thr);
        endcase
        @(posedge clk_i);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // one pixel word, with an optional idle burst ahead of it
  task automatic send_pixel(input pix_t px);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    do @(posedge clk_i); while (!pix_if.ready);
    pixels_sent++;
  endtask

  function automatic pix_t pick_pixel(input fill_e fill, input int unsigned r,
                                      input int unsigned c, input int unsigned level,
                                      input int unsigned salt);
    int v;
    case (fill)
      FillNoise: return pix_t'($urandom_range(0, 255));
      FillNearLevel: begin
        // hover around the threshold so both outcomes show up
        v = int'(level) + int'($urandom_range(0, 30)) - 15;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return pix_t'(v);
      end
      FillBlobs: begin
        if (((r / 2) + (c / 3) + salt) % 2 == 1) return pix_t'(255 - $urandom_range(0, 40));
        return pix_t'($urandom_range(0, 40));
      end
      default: return pix_t'(level);
    endcase
  endfunction

  // raster rows starting at row0; row0 only shapes the pattern
  task automatic send_rows(input int unsigned w, input int unsigned rows,
                           input int unsigned row0, input fill_e fill,
                           input int unsigned level);
    int unsigned salt;
    salt = $urandom_range(0, 7);
    for (int unsigned r = row0; r < row0 + rows; r++)
      for (int unsigned c = 0; c < w; c++)
        send_pixel(pick_pixel(fill, r, c, level, salt));
  endtask

  initial begin
    int unsigned w_raw;
    int unsigned h_raw;
    int unsigned thr;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned target;
    int unsigned level;
    fill_e       fill;
    pix_t        px;

    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CfgImageWidth;
    cfg_data     = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    idle_en      = 1'b1;
    pixels_sent  = 0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sum exactly at threshold*1000 must give white: interior 100 with
    // centre, one mid-outer, one edge and one corner tap raised by one
    // (162+22+13+3 = 200 on top of 998*100); the outer ring, which the only
    // interior window never sees, carries black and white pixels
    write_regs(3'b111, 7, 7, EdgeLevel);
    for (int unsigned r = 0; r < 7; r++) begin
      for (int unsigned c = 0; c < 7; c++) begin
        if (r == 0 || r == 6 || c == 0 || c == 6) px = ((r + c) % 2 == 1) ? PixWhite : PixBlack;
        else px = EdgeLevel;
        if ((r == 3 && (c == 3 || c == 1)) || (c == 1 && (r == 2 || r == 1))) px = EdgeLevel + 1;
        send_pixel(px);
      end
    end

    // sizes below range saturate to 7; threshold 0 turns even black white
    write_regs(3'b111, 0, 0, 0);
    send_rows(7, 7, 0, FillFlat, 0);
    // threshold 255 can never be reached, even by an all-white window
    write_regs(3'b100, 0, 0, 255);
    send_rows(7, 7, 0, FillFlat, 255);

    // widest row: an oversized width saturates to the line store size, so
    // the first row ends at the last line store column; the rest of the
    // frame runs narrow over columns that row already wrote
    write_regs(3'b111, 2047, 7, 128);
    send_rows(MaxWidth, 1, 0, FillNoise, 128);
    write_regs(3'b001, 7, 7, 128);
    send_rows(7, 6, 1, FillNoise, 128);

    // tallest frame, cut short by lowering the height mid-frame
    write_regs(3'b111, 7, MaxHeight, 90);
    send_rows(7, 9, 0, FillNearLevel, 90);
    write_regs(3'b110, 7, 3, 60);
    send_rows(7, 1, 9, FillNearLevel, 60);

    // width shrunk mid-row with the column already past the new last column
    write_regs(3'b111, 12, 9, 110);
    send_rows(12, 5, 0, FillBlobs, 110);
    send_rows(10, 1, 5, FillBlobs, 110);
    write_regs(3'b101, 8, 9, 140);
    send_rows(1, 1, 5, FillBlobs, 140);
    send_rows(8, 3, 6, FillBlobs, 140);

    // random phases: fresh registers, then one to three whole frames each
    target = pixels_sent + RandomItems;
    while (pixels_sent < target) begin
      if (pixels_sent + CalmItems < target) idle_en = ($urandom_range(0, 4) != 0);
      else idle_en = 1'b0;
      case ($urandom_range(0, 9))
        0:       w_raw = $urandom_range(0, 6);
        1:       w_raw = MinSize;
        default: w_raw = $urandom_range(8, 20);
      endcase
      case ($urandom_range(0, 9))
        0:       h_raw = $urandom_range(0, 6);
        1:       h_raw = MinSize;
        default: h_raw = $urandom_range(8, 14);
      endcase
      case ($urandom_range(0, 7))
        0:       thr = 0;
        1:       thr = 255;
        default: thr = $urandom_range(20, 230);
      endcase
      fill  = fill_e'($urandom_range(0, 3));
      level = (fill == FillFlat) ? $urandom_range(0, 255) : thr;
      w_eff = (w_raw < MinSize) ? MinSize : w_raw;
      h_eff = (h_raw < MinSize) ? MinSize : h_raw;
      write_regs(3'b111, w_raw, h_raw, thr);
      repeat ($urandom_range(1, 3)) begin
        if (pixels_sent < target) begin
          // now and then hold the stream until every result is back
          if ($urandom_range(0, 3) == 0) begin
            pix_if.valid <= 1'b0;
            wait_drained();
          end
          send_rows(w_eff, h_eff, 0, fill, level);
        end
      end
    end

    pix_if.valid <= 1'b0;
    wait_drained();

    $display("%0d pixels sent, %0d result words checked (%0d white) over %0d frames",
             pixels_sent, checked, whites, frames);
    $display("sizes 7 to 1024 wide and up to 4095 tall, thresholds 0 to 255, "
             , "mid-frame register changes, sum exactly at threshold");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/gbt_pkg.sv
hw/rtl/gbt_if.sv
hw/rtl/gbt_ram.sv
hw/rtl/gbt_kernel.sv
hw/rtl/gaussian_blur_threshold_5x5_unit.sv
tb/gaussian_blur_threshold_5x5_checker.sv
tb/gaussian_blur_threshold_5x5_unit_test.sv
